// ----- rtl/wls_pkg.sv -----
// ----------------------------------------------------------------------------
// wls_pkg
// Shared types and constants for the wakeup latency statistics block:
// item codes, register indexes, stream field layout and arithmetic constants.
// ----------------------------------------------------------------------------
package wls_pkg;

  // Histogram depth default, handed to the top level parameter
  localparam int HIST_BINS_DEF = 1024;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int SEC_W    = 32;
  localparam int NSEC_W   = 30;
  localparam int BIN_W    = 10;
  localparam int LAT_W    = 32;
  localparam int STAT_W   = 64;
  localparam int CFG_W    = 32;
  localparam int CFG_A_W  = 2;
  localparam int IV_W     = 20;
  localparam int IV_NS_W  = 30;

  // Stream layout: input tdata = now_sec, now_nsec, bin_index (72 bits)
  localparam int IN_TDATA_W   = 72;
  localparam int IN_TUSER_W   = 2;
  // Output tdata = latency, max, min, count, total, bin, hit, finished (258 -> 264)
  localparam int OUT_TDATA_W  = 264;
  localparam int OUT_LAT_LO   = 0;
  localparam int OUT_MAX_LO   = 32;
  localparam int OUT_MIN_LO   = 64;
  localparam int OUT_CNT_LO   = 96;
  localparam int OUT_TOT_LO   = 160;
  localparam int OUT_BIN_LO   = 224;
  localparam int OUT_HIT_BIT  = 256;
  localparam int OUT_FIN_BIT  = 257;
  localparam int OUT_PAD_W    = 6;

  // Time constants
  localparam logic [30:0] NS_PER_S_1 = 31'd1_000_000_000;
  localparam logic [30:0] NS_PER_S_2 = 31'd2_000_000_000;
  localparam logic [9:0]  NS_PER_US  = 10'd1000;
  localparam logic [IV_NS_W-1:0] IV_NS_RST = 30'd1_000_000;

  // floor(x / 1000) = (x * DIV1000_MUL) >> DIV1000_SH, exact for x < 2^32
  localparam logic [28:0] DIV1000_MUL = 29'd274_877_907;
  localparam int          DIV1000_SH  = 38;
  localparam logic signed [34:0] US_PER_S = 35'sd1_000_000;

  // Seconds difference past which the latency saturates
  localparam logic signed [32:0] SEC_DIFF_SAT = 33'sd4295;

  // Item kinds
  typedef enum logic [ACTION_W-1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  // Register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_BREAK    = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_idx_t;

  // Live configuration
  typedef struct packed {
    logic [IV_NS_W-1:0] iv_ns;
    logic [LAT_W-1:0]   thr;
    logic [CFG_W-1:0]   limit;
  } cfg_t;

  // Item leaving the latency pipeline
  typedef struct packed {
    logic             valid;
    action_t          action;
    logic [BIN_W-1:0] bin_index;
    logic [LAT_W-1:0] lat;
  } lat_item_t;

endpackage

// ----- rtl/wls_latency.sv -----
// ----------------------------------------------------------------------------
// wls_latency
// Deadline tracking and four-stage latency pipeline: deadline advance,
// seconds difference, divide by 1000 through a reciprocal multiply, clamp.
// ----------------------------------------------------------------------------
module wls_latency (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        in_fire,
  input  wls_pkg::action_t            in_action,
  input  logic [wls_pkg::SEC_W-1:0]   in_now_sec,
  input  logic [wls_pkg::NSEC_W-1:0]  in_now_nsec,
  input  logic [wls_pkg::BIN_W-1:0]   in_bin_index,
  input  logic [wls_pkg::IV_NS_W-1:0] iv_ns,
  output wls_pkg::lat_item_t          p4_o
);

  // Deadline state
  logic [wls_pkg::SEC_W-1:0]  dl_sec_r, dl_sec_nxt;
  logic [wls_pkg::NSEC_W-1:0] dl_nsec_r, dl_nsec_nxt;
  logic [wls_pkg::SEC_W-1:0]  base_sec;
  logic [wls_pkg::NSEC_W-1:0] base_nsec;
  logic [30:0]                nsec_sum;
  logic                       dl_load;

  // Stage 1
  logic                       p1_valid_r;
  wls_pkg::action_t           p1_action_r;
  logic [wls_pkg::BIN_W-1:0]  p1_bin_r;
  logic [wls_pkg::SEC_W-1:0]  p1_now_sec_r, p1_dl_sec_r;
  logic [wls_pkg::NSEC_W-1:0] p1_now_nsec_r, p1_dl_nsec_r;
  logic signed [32:0]         sec_diff;
  logic                       p2_sat_nxt, p2_neg_nxt;
  logic signed [13:0]         p2_dp_nxt;
  logic [30:0]                p2_ndp_nxt;

  // Stage 2
  logic                       p2_valid_r;
  wls_pkg::action_t           p2_action_r;
  logic [wls_pkg::BIN_W-1:0]  p2_bin_r;
  logic                       p2_sat_r, p2_neg_r;
  logic signed [13:0]         p2_dp_r;
  logic [30:0]                p2_ndp_r;
  logic signed [34:0]         dp_ext;
  logic signed [34:0]         p3_m_nxt;
  logic [59:0]                q_prod;
  logic [20:0]                p3_q_nxt;

  // Stage 3
  logic                       p3_valid_r;
  wls_pkg::action_t           p3_action_r;
  logic [wls_pkg::BIN_W-1:0]  p3_bin_r;
  logic                       p3_sat_r, p3_neg_r;
  logic signed [34:0]         p3_m_r;
  logic [20:0]                p3_q_r;
  logic signed [34:0]         lat_sum;
  logic [wls_pkg::LAT_W-1:0]  p4_lat_nxt;

  // Stage 4
  logic                       p4_valid_r;
  wls_pkg::action_t           p4_action_r;
  logic [wls_pkg::BIN_W-1:0]  p4_bin_r;
  logic [wls_pkg::LAT_W-1:0]  p4_lat_r;

  // Advance the deadline by one interval and normalize nanoseconds
  always_comb begin
    base_sec  = (in_action == wls_pkg::ACT_START) ? in_now_sec : dl_sec_r;
    base_nsec = (in_action == wls_pkg::ACT_START) ? in_now_nsec : dl_nsec_r;
    nsec_sum  = 31'(base_nsec) + 31'(iv_ns);
    priority if (nsec_sum >= wls_pkg::NS_PER_S_2) begin
      dl_sec_nxt  = base_sec + 32'd2;
      dl_nsec_nxt = 30'(nsec_sum - wls_pkg::NS_PER_S_2);
    end else if (nsec_sum >= wls_pkg::NS_PER_S_1) begin
      dl_sec_nxt  = base_sec + 32'd1;
      dl_nsec_nxt = 30'(nsec_sum - wls_pkg::NS_PER_S_1);
    end else begin
      dl_sec_nxt  = base_sec;
      dl_nsec_nxt = 30'(nsec_sum);
    end
  end

  // Samples past a stop advance the deadline too; it is never used after a stop
  assign dl_load = in_fire &&
                   (in_action == wls_pkg::ACT_START || in_action == wls_pkg::ACT_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_sec_r  <= '0;
      dl_nsec_r <= '0;
    end else if (dl_load) begin
      dl_sec_r  <= dl_sec_nxt;
      dl_nsec_r <= dl_nsec_nxt;
    end
  end

  // Stage 1: seconds difference, shifted by one second so nanoseconds stay positive
  always_comb begin
    sec_diff   = $signed({1'b0, p1_now_sec_r}) - $signed({1'b0, p1_dl_sec_r});
    p2_sat_nxt = sec_diff > wls_pkg::SEC_DIFF_SAT;
    p2_neg_nxt = sec_diff < -33'sd1;
    p2_dp_nxt  = 14'(sec_diff - 33'sd1);
    p2_ndp_nxt = 31'(p1_now_nsec_r) + wls_pkg::NS_PER_S_1 - 31'(p1_dl_nsec_r);
  end

  // Stage 2: whole seconds to microseconds, nanoseconds to microseconds
  always_comb begin
    dp_ext   = {{21{p2_dp_r[13]}}, p2_dp_r};
    p3_m_nxt = dp_ext * wls_pkg::US_PER_S;
    q_prod   = 60'(p2_ndp_r) * 60'(wls_pkg::DIV1000_MUL);
    p3_q_nxt = q_prod[wls_pkg::DIV1000_SH +: 21];
  end

  // Stage 3: combine, clamp negatives to zero, saturate at 32 bits
  always_comb begin
    lat_sum = p3_m_r + $signed({14'd0, p3_q_r});
    priority if (p3_sat_r) begin
      p4_lat_nxt = '1;
    end else if (p3_neg_r || lat_sum <= 35'sd0) begin
      p4_lat_nxt = '0;
    end else if (lat_sum[34:32] != 3'd0) begin
      p4_lat_nxt = '1;
    end else begin
      p4_lat_nxt = lat_sum[31:0];
    end
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
    end else if (step) begin
      p1_valid_r <= in_fire;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (step) begin
      p1_action_r   <= in_action;
      p1_bin_r      <= in_bin_index;
      p1_now_sec_r  <= in_now_sec;
      p1_now_nsec_r <= in_now_nsec;
      p1_dl_sec_r   <= dl_sec_nxt;
      p1_dl_nsec_r  <= dl_nsec_nxt;

      p2_action_r <= p1_action_r;
      p2_bin_r    <= p1_bin_r;
      p2_sat_r    <= p2_sat_nxt;
      p2_neg_r    <= p2_neg_nxt;
      p2_dp_r     <= p2_dp_nxt;
      p2_ndp_r    <= p2_ndp_nxt;

      p3_action_r <= p2_action_r;
      p3_bin_r    <= p2_bin_r;
      p3_sat_r    <= p2_sat_r;
      p3_neg_r    <= p2_neg_r;
      p3_m_r      <= p3_m_nxt;
      p3_q_r      <= p3_q_nxt;

      p4_action_r <= p3_action_r;
      p4_bin_r    <= p3_bin_r;
      p4_lat_r    <= p4_lat_nxt;
    end
  end

  assign p4_o.valid     = p4_valid_r;
  assign p4_o.action    = p4_action_r;
  assign p4_o.bin_index = p4_bin_r;
  assign p4_o.lat       = p4_lat_r;

endmodule

// ----- rtl/wls_hist.sv -----
// ----------------------------------------------------------------------------
// wls_hist
// Histogram memory: one write and one registered read port, a clearing pass
// after reset, and forwarding of the previous write to the read in flight.
// ----------------------------------------------------------------------------
module wls_hist #(
  parameter  int HIST_BINS = wls_pkg::HIST_BINS_DEF,
  localparam int AW        = $clog2(HIST_BINS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [AW-1:0]              rd_addr,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [wls_pkg::LAT_W-1:0]  wr_data,
  output logic [wls_pkg::LAT_W-1:0]  cur_data,
  output logic                       busy
);

  logic [wls_pkg::LAT_W-1:0] mem [0:HIST_BINS-1];
  logic [wls_pkg::LAT_W-1:0] rd_data_r;
  logic [AW-1:0]             rd_addr_r;
  logic                      lw_valid_r;
  logic [AW-1:0]             lw_addr_r;
  logic [wls_pkg::LAT_W-1:0] lw_data_r;
  logic                      clr_active_r, clr_active_nxt;
  logic [AW-1:0]             clr_addr_r, clr_addr_nxt;
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [wls_pkg::LAT_W-1:0] mem_wd;

  // Walk the memory once after reset, writing zeros
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(HIST_BINS - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // Write port: clearing pass, else bin update
  always_comb begin
    mem_we = clr_active_r || wr_en;
    mem_wa = clr_active_r ? clr_addr_r : wr_addr;
    mem_wd = clr_active_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (step) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Hold the last write so the read issued alongside it sees the new count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (step) begin
      lw_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

  assign cur_data = (lw_valid_r && lw_addr_r == rd_addr_r) ? lw_data_r : rd_data_r;
  assign busy     = clr_active_r;

endmodule

// ----- rtl/wls_stats.sv -----
// ----------------------------------------------------------------------------
// wls_stats
// Commit stage: issues the histogram read, updates max, min, count, total and
// the stop flag in order, writes the bin back and registers the result.
// ----------------------------------------------------------------------------
module wls_stats #(
  parameter  int HIST_BINS = wls_pkg::HIST_BINS_DEF,
  localparam int AW        = $clog2(HIST_BINS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  wls_pkg::lat_item_t               p4_i,
  input  wls_pkg::cfg_t                    cfg_i,
  input  logic [wls_pkg::LAT_W-1:0]        cur_data,
  output logic [AW-1:0]                    rd_addr,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [wls_pkg::LAT_W-1:0]        wr_data,
  output logic                             out_valid,
  output logic [wls_pkg::OUT_TDATA_W-1:0]  out_data
);

  // Read issue stage
  logic                       p5_inr_nxt;
  logic                       p5_valid_r;
  wls_pkg::action_t           p5_action_r;
  logic [wls_pkg::LAT_W-1:0]  p5_lat_r;
  logic [AW-1:0]              p5_addr_r;
  logic                       p5_inr_r;

  // Running statistics
  logic [wls_pkg::LAT_W-1:0]  max_r, max_nxt;
  logic [wls_pkg::LAT_W-1:0]  min_r, min_nxt;
  logic [wls_pkg::STAT_W-1:0] cnt_r, cnt_nxt;
  logic [wls_pkg::STAT_W-1:0] tot_r, tot_nxt;
  logic                       stopped_r, stopped_nxt;
  logic [wls_pkg::STAT_W:0]   tot_sum;
  logic                       smp;
  logic [wls_pkg::LAT_W-1:0]  lat_c;
  logic                       hit;
  logic [wls_pkg::LAT_W-1:0]  bin_v;

  // Output register
  logic                             out_valid_r;
  logic [wls_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  // Pick the bin to read: the latency for samples, the index for reads
  always_comb begin
    if (p4_i.action == wls_pkg::ACT_SAMPLE) begin
      rd_addr    = AW'(p4_i.lat);
      p5_inr_nxt = p4_i.lat < 32'(HIST_BINS);
    end else begin
      rd_addr    = AW'(p4_i.bin_index);
      p5_inr_nxt = {22'd0, p4_i.bin_index} < 32'(HIST_BINS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_valid_r <= 1'b0;
    end else if (step) begin
      p5_valid_r <= p4_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      p5_action_r <= p4_i.action;
      p5_lat_r    <= p4_i.lat;
      p5_addr_r   <= rd_addr;
      p5_inr_r    <= p5_inr_nxt;
    end
  end

  // Commit one item; samples after a stop change nothing
  always_comb begin
    smp     = p5_valid_r && p5_action_r == wls_pkg::ACT_SAMPLE && !stopped_r;
    lat_c   = smp ? p5_lat_r : '0;
    max_nxt = (smp && p5_lat_r > max_r) ? p5_lat_r : max_r;
    min_nxt = (smp && p5_lat_r < min_r) ? p5_lat_r : min_r;
    cnt_nxt = (smp && cnt_r != '1) ? cnt_r + 64'd1 : cnt_r;
    tot_sum = {1'b0, tot_r} + {33'd0, lat_c};
    tot_nxt = tot_sum[wls_pkg::STAT_W] ? '1 : tot_sum[wls_pkg::STAT_W-1:0];
    hit     = smp && p5_lat_r > cfg_i.thr;
    stopped_nxt = stopped_r || hit ||
                  (smp && cfg_i.limit != '0 && cnt_nxt >= {32'd0, cfg_i.limit});
    bin_v   = (p5_valid_r && p5_action_r == wls_pkg::ACT_READ && p5_inr_r) ?
              cur_data : '0;
    out_data_nxt = {{wls_pkg::OUT_PAD_W{1'b0}}, stopped_nxt, hit, bin_v,
                    tot_nxt, cnt_nxt, min_nxt, max_nxt, lat_c};
  end

  // Bin write back, saturating
  assign wr_en   = step && smp && p5_inr_r && cur_data != '1;
  assign wr_addr = p5_addr_r;
  assign wr_data = cur_data + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= '0;
      min_r     <= '1;
      cnt_r     <= '0;
      tot_r     <= '0;
      stopped_r <= 1'b0;
    end else if (step) begin
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      cnt_r     <= cnt_nxt;
      tot_r     <= tot_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // Result register; refilled when the pipeline steps with an item in the commit stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= p5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step && p5_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/wakeup_latency_statistics.sv -----
// ----------------------------------------------------------------------------
// wakeup_latency_statistics
// Periodic-deadline latency monitor with running statistics and a histogram.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): in_tuser carries the item kind (start, sample, read
//   bin); in_tdata carries the timestamp and the bin index. Every accepted
//   item gives exactly one result on the output stream (out_*), in order.
//   Configuration (cfg_*): interval, break threshold and loop limit are
//   written with cfg_we; write them only while no item is in flight.
//   Throughput: one item per cycle while out_tready does not stall the output
//   and the clearing pass is over. A result passes, in order, through deadline update,
//   seconds difference, reciprocal multiply, clamp, histogram memory read, commit.
//   Read, increment and write back of a bin share one memory port pair; the
//   write of each cycle is forwarded to the read issued with it.
//   Reset: after rst_n the histogram memory is cleared one bin per cycle,
//   through every bin, with in_tready low; configuration writes are taken.
//   Stall: the output is registered; while out_tready is low with a result
//   pending the whole pipeline holds and in_tready drops in the same cycle.
// ----------------------------------------------------------------------------
module wakeup_latency_statistics #(
  parameter int HIST_BINS = wls_pkg::HIST_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] now_sec, [61:32] now_nsec, [71:62] bin_index
  input  logic [wls_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] action
  input  logic [wls_pkg::IN_TUSER_W-1:0]      in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] latency_us, [63:32] max_us, [95:64] min_us, [159:96] sample_count,
  // [223:160] total_us, [255:224] bin_value, [256] break_hit, [257] finished,
  // [263:258] zero
  output logic [wls_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Configuration
  input  logic                                cfg_we,
  input  logic [wls_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [wls_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int AW = $clog2(HIST_BINS);

  wls_pkg::cfg_t             cfg_r;
  logic                      step;
  logic                      in_fire;
  logic                      busy;
  wls_pkg::lat_item_t        p4;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [wls_pkg::LAT_W-1:0] wr_data;
  logic [wls_pkg::LAT_W-1:0] cur_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.iv_ns <= wls_pkg::IV_NS_RST;
      cfg_r.thr   <= '1;
      cfg_r.limit <= '0;
    end else if (cfg_we) begin
      unique case (wls_pkg::cfg_idx_t'(cfg_addr))
        wls_pkg::CFG_INTERVAL: begin
          cfg_r.iv_ns <= 30'(cfg_wdata[wls_pkg::IV_W-1:0]) * 30'(wls_pkg::NS_PER_US);
        end
        wls_pkg::CFG_BREAK: begin
          cfg_r.thr <= cfg_wdata;
        end
        wls_pkg::CFG_LIMIT: begin
          cfg_r.limit <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Advance whenever the result register is empty or being drained
  assign step      = !out_tvalid || out_tready;
  assign in_tready = step && !busy;
  assign in_fire   = in_tvalid && in_tready;

  wls_latency u_latency (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .in_fire      (in_fire),
    .in_action    (wls_pkg::action_t'(in_tuser)),
    .in_now_sec   (in_tdata[31:0]),
    .in_now_nsec  (in_tdata[61:32]),
    .in_bin_index (in_tdata[71:62]),
    .iv_ns        (cfg_r.iv_ns),
    .p4_o         (p4)
  );

  wls_hist #(
    .HIST_BINS (HIST_BINS)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .cur_data (cur_data),
    .busy     (busy)
  );

  wls_stats #(
    .HIST_BINS (HIST_BINS)
  ) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .p4_i      (p4),
    .cfg_i     (cfg_r),
    .cur_data  (cur_data),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

// ----- rtl/wls_checker.sv -----
// ----------------------------------------------------------------------------
// wls_checker
// Port-level checks for the wakeup latency statistics block, bound to the
// top level.
// ----------------------------------------------------------------------------
module wls_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [wls_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [wls_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [wls_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [wls_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [wls_pkg::CFG_W-1:0]           cfg_wdata
);

  logic out_xfer;
  logic fin_seen_r;

  assign out_xfer = out_tvalid && out_tready;

  // Track whether any result has reported a stop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_seen_r <= 1'b0;
    end else if (out_xfer && out_tdata[wls_pkg::OUT_FIN_BIT]) begin
      fin_seen_r <= 1'b1;
    end
  end

  // A pending result stays until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Once stopped, the block stays stopped until reset
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && fin_seen_r) |-> out_tdata[wls_pkg::OUT_FIN_BIT])
    else $error("finished cleared without reset");

  // A break always stops the block
  a_hit_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tdata[wls_pkg::OUT_HIT_BIT]) |-> out_tdata[wls_pkg::OUT_FIN_BIT])
    else $error("break reported without stop");

  // With samples counted, min never exceeds max
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tdata[wls_pkg::OUT_CNT_LO +: wls_pkg::STAT_W] != '0) |->
    (out_tdata[wls_pkg::OUT_MIN_LO +: wls_pkg::LAT_W] <=
     out_tdata[wls_pkg::OUT_MAX_LO +: wls_pkg::LAT_W]))
    else $error("min latency above max latency");

  // Input and configuration ports are observed only through the bind
  logic unused_ok;
  assign unused_ok = ^{in_tvalid, in_tready, in_tdata, in_tuser, cfg_we, cfg_addr, cfg_wdata};

endmodule

bind wakeup_latency_statistics wls_checker u_wls_checker (.*);
